>>> rtl/tak_pkg.sv
// ============================================================================
// tak_pkg: shared types and constants of the tilt angle Kalman filter
// Register indexes, operation codes, reset values and the saturation helper.
// ============================================================================
`default_nettype none

package tak_pkg;

    typedef logic signed [31:0] t_word;
    typedef logic [2:0]         t_reg_index;

    // Fraction bits of time step, noise terms, covariance and gains.
    localparam int COV_FRAC_BITS = 24;

    localparam t_reg_index REG_TIME_STEP    = 3'd0;
    localparam t_reg_index REG_ANGLE_NOISE  = 3'd1;
    localparam t_reg_index REG_BIAS_NOISE   = 3'd2;
    localparam t_reg_index REG_MEASURE_NOISE = 3'd3;
    localparam t_reg_index REG_INITIAL_BIAS = 3'd4;

    // Operation carried in the input word's tuser.
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [30:0] RST_TIME_STEP     = 31'd167772;
    localparam logic [30:0] RST_ANGLE_NOISE   = 31'd167772;
    localparam logic [30:0] RST_BIAS_NOISE    = 31'd838861;
    localparam logic [30:0] RST_MEASURE_NOISE = 31'd167772;

    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic t_word sat32(input logic signed [69:0] v);
        t_word res;
        if (v > 70'sd2147483647) begin
            res = WORD_MAX;
        end else if (v < -70'sd2147483648) begin
            res = WORD_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tilt_angle_kalman_filter.sv
// ============================================================================
// tilt_angle_kalman_filter: two-state angle and gyro bias Kalman filter
// Fuses an accelerometer tilt angle with a gyro rate, one word at a time.
// ============================================================================
// One input word is either a sample (tuser 0) or a restart (tuser 1). For a
// sample the arithmetic runs on one shared 34 by 34 bit multiplier under a
// small sequencer, and the two gains are computed in turn by a restoring
// divider that produces one quotient bit per cycle; no division runs when the
// innovation variance is zero. A restart goes straight to the final state.
// The input side is not ready while a word is in work; a finished result sits
// in an output register, so the block returns to ready as soon as that
// register is free. Configuration is written through a separate channel that
// is always ready and should only be used while idle.
// Angles, rates and bias are signed Q16.16; time step, noise terms, covariance
// and gains are Q(32-C).C with C = COV_FRAC_BITS. All products round half up
// and every intermediate result but the innovation variance saturates to
// signed 32 bits.
`default_nettype none

module tilt_angle_kalman_filter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write channel.
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    // Input words.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [31:0] measured_angle, [63:32] gyro_rate
    input  wire         s_axis_tuser,   // [0] operation
    // Result words.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] angle_estimate, [63:32] bias_estimate
    output logic        m_axis_tuser    // [0] divide_fault
);

    localparam int C      = tak_pkg::COV_FRAC_BITS;
    localparam int DW     = 65;           // divider compare width
    localparam int QW     = 33;           // quotient bits, top bit flags overflow
    localparam int PW     = 68;           // product width

    // Sequencer states.
    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_ANG    = 5'd1;
    localparam logic [4:0] ST_TMUL   = 5'd2;
    localparam logic [4:0] ST_INNER  = 5'd3;
    localparam logic [4:0] ST_IMUL   = 5'd4;
    localparam logic [4:0] ST_P00    = 5'd5;
    localparam logic [4:0] ST_SETUP  = 5'd6;
    localparam logic [4:0] ST_DIV    = 5'd7;
    localparam logic [4:0] ST_DIVEND = 5'd8;
    localparam logic [4:0] ST_ERR    = 5'd9;
    localparam logic [4:0] ST_UPA    = 5'd10;
    localparam logic [4:0] ST_UPB    = 5'd11;
    localparam logic [4:0] ST_UC0    = 5'd12;
    localparam logic [4:0] ST_UC1    = 5'd13;
    localparam logic [4:0] ST_UC2    = 5'd14;
    localparam logic [4:0] ST_UC3    = 5'd15;
    localparam logic [4:0] ST_UC4    = 5'd16;
    localparam logic [4:0] ST_FIN    = 5'd17;

    // Configuration registers.
    logic [30:0]     r_dt, r_qa, r_qb, r_rn;
    tak_pkg::t_word  r_init_bias;
    // Filter state.
    tak_pkg::t_word  r_angle, r_bias, r_p00, r_p01, r_p10, r_p11;
    tak_pkg::t_word  n_angle, n_bias, n_p00, n_p01, n_p10, n_p11;
    // Predicted covariance and working values.
    tak_pkg::t_word  r_a00, r_a01, r_a10, r_a11, r_inner, r_k0, r_k1, r_err;
    tak_pkg::t_word  n_a00, n_a01, n_a10, n_a11, n_inner, n_k0, n_k1, n_err;
    tak_pkg::t_word  r_meas, r_rate, n_meas, n_rate;
    logic            r_fault, n_fault;
    logic [4:0]      r_state, n_state;
    // Divider.
    logic [DW-1:0]   r_rem, r_dsh, n_rem, n_dsh;
    logic [QW-1:0]   r_q, n_q;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_neg, n_neg, r_sel, n_sel;
    logic [32:0]     r_smag, n_smag;
    logic            r_sneg, n_sneg;
    // Multiplier.
    logic signed [PW-1:0] r_prod, n_prod;
    logic signed [33:0]   w_ma, w_mb;
    logic                 w_mul;
    // Output register.
    logic            r_mvalid, n_mvalid;
    logic [63:0]     r_mdata, n_mdata;
    logic            r_muser, n_muser;

    logic signed [PW-1:0] w_rnd, w_shr;
    tak_pkg::t_word       w_mq;
    logic signed [33:0]   w_s;
    logic                 w_ge;
    tak_pkg::t_word       w_quot;
    logic signed [33:0]   w_dt;

    assign w_dt = 34'($unsigned(r_dt));

    // Rounded, rescaled and clamped view of the last product.
    assign w_rnd = r_prod + (PW'(1) <<< (C - 1));
    assign w_shr = w_rnd >>> C;
    assign w_mq  = tak_pkg::sat32(70'(w_shr));

    assign w_s  = 34'(r_a00) + 34'($unsigned(r_rn));
    assign w_ge = (r_rem >= r_dsh);

    // Signed, clamped quotient from the divider's magnitude.
    always_comb begin
        if (r_neg) begin
            if (r_q[QW-1] || (r_q[31:0] > 32'h8000_0000)) begin
                w_quot = tak_pkg::WORD_MIN;
            end else begin
                w_quot = -$signed(r_q[31:0]);
            end
        end else begin
            if (r_q[QW-1] || r_q[31]) begin
                w_quot = tak_pkg::WORD_MAX;
            end else begin
                w_quot = $signed(r_q[31:0]);
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

    always_comb begin
        logic [31:0] v_mag;
        tak_pkg::t_word v_num;
        v_mag   = '0;
        v_num   = '0;
        n_state = r_state;
        n_angle = r_angle;  n_bias = r_bias;
        n_p00 = r_p00;  n_p01 = r_p01;  n_p10 = r_p10;  n_p11 = r_p11;
        n_a00 = r_a00;  n_a01 = r_a01;  n_a10 = r_a10;  n_a11 = r_a11;
        n_inner = r_inner;  n_k0 = r_k0;  n_k1 = r_k1;  n_err = r_err;
        n_meas = r_meas;  n_rate = r_rate;  n_fault = r_fault;
        n_rem = r_rem;  n_dsh = r_dsh;  n_q = r_q;  n_cnt = r_cnt;
        n_neg = r_neg;  n_sel = r_sel;  n_smag = r_smag;  n_sneg = r_sneg;
        n_mvalid = r_mvalid && !m_axis_tready;
        n_mdata  = r_mdata;
        n_muser  = r_muser;
        w_mul = 1'b0;
        w_ma  = '0;
        w_mb  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == tak_pkg::OP_RESTART) begin
                        n_angle = '0;
                        n_bias  = r_init_bias;
                        n_p00 = '0;  n_p01 = '0;  n_p10 = '0;  n_p11 = '0;
                        n_fault = 1'b0;
                        n_state = ST_FIN;
                    end else begin
                        n_meas  = s_axis_tdata[31:0];
                        n_rate  = s_axis_tdata[63:32];
                        n_state = ST_ANG;
                    end
                end
            end
            ST_ANG: begin
                w_mul = 1'b1;
                w_ma  = w_dt;
                w_mb  = 34'(r_rate) - 34'(r_bias);
                n_state = ST_TMUL;
            end
            ST_TMUL: begin
                n_angle = tak_pkg::sat32(70'(r_angle) + 70'(w_mq));
                w_mul = 1'b1;
                w_ma  = w_dt;
                w_mb  = 34'(r_p11);
                n_state = ST_INNER;
            end
            ST_INNER: begin
                // w_mq holds dt * P11 here.
                n_inner = tak_pkg::sat32(70'(w_mq) - 70'(r_p01) - 70'(r_p10));
                n_a01   = tak_pkg::sat32(70'(r_p01) - 70'(w_mq));
                n_a10   = tak_pkg::sat32(70'(r_p10) - 70'(w_mq));
                n_a11   = tak_pkg::sat32(70'(r_p11) + 70'($unsigned(r_qb)));
                n_state = ST_IMUL;
            end
            ST_IMUL: begin
                w_mul = 1'b1;
                w_ma  = w_dt;
                w_mb  = 34'(r_inner);
                n_state = ST_P00;
            end
            ST_P00: begin
                n_a00 = tak_pkg::sat32(70'(r_p00) + 70'(w_mq) + 70'($unsigned(r_qa)));
                n_state = ST_SETUP;
            end
            ST_SETUP: begin
                if (w_s == 34'sd0) begin
                    n_k0 = '0;
                    n_k1 = '0;
                    n_fault = 1'b1;
                    n_state = ST_ERR;
                end else begin
                    n_fault = 1'b0;
                    n_sneg  = w_s[33];
                    n_smag  = w_s[33] ? 33'(-w_s) : w_s[32:0];
                    v_mag   = r_a00[31] ? 32'(-r_a00) : r_a00;
                    n_rem   = DW'(v_mag) << C;
                    n_dsh   = (w_s[33] ? DW'(33'(-w_s)) : DW'(w_s[32:0])) << 32;
                    n_neg   = r_a00[31] ^ w_s[33];
                    n_q     = '0;
                    n_cnt   = '0;
                    n_sel   = 1'b0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // One quotient bit per cycle, most significant first.
                if (w_ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_q   = {r_q[QW-2:0], w_ge};
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(QW - 1)) begin
                    n_state = ST_DIVEND;
                end
            end
            ST_DIVEND: begin
                if (!r_sel) begin
                    n_k0   = w_quot;
                    v_num  = r_a10;
                    v_mag  = v_num[31] ? 32'(-v_num) : v_num;
                    n_rem  = DW'(v_mag) << C;
                    n_dsh  = DW'(r_smag) << 32;
                    n_neg  = v_num[31] ^ r_sneg;
                    n_q    = '0;
                    n_cnt  = '0;
                    n_sel  = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    n_k1    = w_quot;
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                n_err   = tak_pkg::sat32(70'(r_meas) - 70'(r_angle));
                n_state = ST_UPA;
            end
            ST_UPA: begin
                w_mul = 1'b1;
                w_ma  = 34'(r_k0);
                w_mb  = 34'(r_err);
                n_state = ST_UPB;
            end
            ST_UPB: begin
                n_angle = tak_pkg::sat32(70'(r_angle) + 70'(w_mq));
                w_mul = 1'b1;
                w_ma  = 34'(r_k1);
                w_mb  = 34'(r_err);
                n_state = ST_UC0;
            end
            ST_UC0: begin
                n_bias = tak_pkg::sat32(70'(r_bias) + 70'(w_mq));
                w_mul = 1'b1;
                w_ma  = 34'(r_k0);
                w_mb  = 34'(r_a00);
                n_state = ST_UC1;
            end
            ST_UC1: begin
                n_p00 = tak_pkg::sat32(70'(r_a00) - 70'(w_mq));
                w_mul = 1'b1;
                w_ma  = 34'(r_k0);
                w_mb  = 34'(r_a01);
                n_state = ST_UC2;
            end
            ST_UC2: begin
                n_p01 = tak_pkg::sat32(70'(r_a01) - 70'(w_mq));
                w_mul = 1'b1;
                w_ma  = 34'(r_k1);
                w_mb  = 34'(r_a00);
                n_state = ST_UC3;
            end
            ST_UC3: begin
                n_p10 = tak_pkg::sat32(70'(r_a10) - 70'(w_mq));
                w_mul = 1'b1;
                w_ma  = 34'(r_k1);
                w_mb  = 34'(r_a01);
                n_state = ST_UC4;
            end
            ST_UC4: begin
                n_p11 = tak_pkg::sat32(70'(r_a11) - 70'(w_mq));
                n_state = ST_FIN;
            end
            ST_FIN: begin
                // Hand the word to the output register once it is free.
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid = 1'b1;
                    n_mdata  = {r_bias, r_angle};
                    n_muser  = r_fault;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Both operands are sign extended to the full product width.
        n_prod = w_mul ? w_ma * w_mb : r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mvalid    <= 1'b0;
            r_dt        <= tak_pkg::RST_TIME_STEP;
            r_qa        <= tak_pkg::RST_ANGLE_NOISE;
            r_qb        <= tak_pkg::RST_BIAS_NOISE;
            r_rn        <= tak_pkg::RST_MEASURE_NOISE;
            r_init_bias <= '0;
            r_angle     <= '0;
            r_bias      <= '0;
            r_p00       <= '0;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= '0;
        end else begin
            r_state  <= n_state;
            r_mvalid <= n_mvalid;
            r_angle  <= n_angle;
            r_bias   <= n_bias;
            r_p00    <= n_p00;
            r_p01    <= n_p01;
            r_p10    <= n_p10;
            r_p11    <= n_p11;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tak_pkg::REG_TIME_STEP:     r_dt <= i_cfg_data[30:0];
                    tak_pkg::REG_ANGLE_NOISE:   r_qa <= i_cfg_data[30:0];
                    tak_pkg::REG_BIAS_NOISE:    r_qb <= i_cfg_data[30:0];
                    tak_pkg::REG_MEASURE_NOISE: r_rn <= i_cfg_data[30:0];
                    tak_pkg::REG_INITIAL_BIAS:  r_init_bias <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a00 <= n_a00;  r_a01 <= n_a01;  r_a10 <= n_a10;  r_a11 <= n_a11;
        r_inner <= n_inner;  r_k0 <= n_k0;  r_k1 <= n_k1;  r_err <= n_err;
        r_meas <= n_meas;  r_rate <= n_rate;  r_fault <= n_fault;
        r_rem <= n_rem;  r_dsh <= n_dsh;  r_q <= n_q;  r_cnt <= n_cnt;
        r_neg <= n_neg;  r_sel <= n_sel;  r_smag <= n_smag;  r_sneg <= n_sneg;
        r_prod <= n_prod;
        r_mdata <= n_mdata;
        r_muser <= n_muser;
    end

    // An accepted word keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // A new result only appears out of the final state.
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_mvalid && !(r_mvalid && !m_axis_tready)) |-> (r_state == ST_FIN))
        else $error("result loaded outside final state");

    // The divider never runs past its last quotient bit.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt < 6'(QW)))
        else $error("divider count overrun");

    // A zero innovation variance leaves both gains at zero.
    a_fault_gains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERR && r_fault) |-> (r_k0 == '0 && r_k1 == '0))
        else $error("nonzero gain with divide fault");

endmodule

`default_nettype wire

>>> tb/tilt_angle_kalman_filter_checker.sv
// ============================================================================
// tilt_angle_kalman_filter_checker: result predictor and comparator
// Follows the configuration and input channels, predicts each result word
// and compares it field by field with what the filter produces.
// ============================================================================
`default_nettype none

module tilt_angle_kalman_filter_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [63:0] i_in_data,
    input  wire         i_in_user,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [63:0] i_out_data,
    input  wire         i_out_user,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFB = tak_pkg::COV_FRAC_BITS;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] bias;
        logic        fault;
    } t_estimate;

    longint dt_reg, qa_reg, qb_reg, r_reg, bias0_reg;
    longint angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
    t_estimate estimate_queue[$];
    int fails;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Fixed-point product, rounded half up, then clamped.
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (CFB - 1));
        return clamp32(p >>> CFB);
    endfunction

    function automatic t_estimate filter_word(logic restart, logic [63:0] d);
        t_estimate e;
        longint meas, rate, ang, bias, t, inner, s, k0, k1, err, p00, p01, p10, p11;
        e.fault = 1'b0;
        if (restart) begin
            angle_q = 0; bias_q = bias0_reg;
            p00_q = 0; p01_q = 0; p10_q = 0; p11_q = 0;
        end else begin
            meas = longint'($signed(d[31:0]));
            rate = longint'($signed(d[63:32]));
            ang = clamp32(angle_q + qmul(dt_reg, rate - bias_q));
            bias = bias_q;
            t = qmul(dt_reg, p11_q);
            inner = clamp32(t - p01_q - p10_q);
            p00 = clamp32(p00_q + qmul(dt_reg, inner) + qa_reg);
            p01 = clamp32(p01_q - t);
            p10 = clamp32(p10_q - t);
            p11 = clamp32(p11_q + qb_reg);
            s = p00 + r_reg;
            if (s == 0) begin
                k0 = 0; k1 = 0; e.fault = 1'b1;
            end else begin
                k0 = clamp32((p00 * (64'sd1 <<< CFB)) / s);
                k1 = clamp32((p10 * (64'sd1 <<< CFB)) / s);
            end
            err = clamp32(meas - ang);
            ang = clamp32(ang + qmul(k0, err));
            bias = clamp32(bias + qmul(k1, err));
            p00_q = clamp32(p00 - qmul(k0, p00));
            p01_q = clamp32(p01 - qmul(k0, p01));
            p10_q = clamp32(p10 - qmul(k1, p00));
            p11_q = clamp32(p11 - qmul(k1, p01));
            angle_q = ang; bias_q = bias;
        end
        e.angle = angle_q[31:0];
        e.bias = bias_q[31:0];
        return e;
    endfunction

    always @(posedge i_clk) begin
        t_estimate want;
        if (!i_rst_n) begin
            dt_reg = tak_pkg::RST_TIME_STEP; qa_reg = tak_pkg::RST_ANGLE_NOISE;
            qb_reg = tak_pkg::RST_BIAS_NOISE; r_reg = tak_pkg::RST_MEASURE_NOISE;
            bias0_reg = 0;
            angle_q = 0; bias_q = 0; p00_q = 0; p01_q = 0; p10_q = 0; p11_q = 0;
            estimate_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tak_pkg::REG_TIME_STEP:     dt_reg = i_cfg_data[30:0];
                    tak_pkg::REG_ANGLE_NOISE:   qa_reg = i_cfg_data[30:0];
                    tak_pkg::REG_BIAS_NOISE:    qb_reg = i_cfg_data[30:0];
                    tak_pkg::REG_MEASURE_NOISE: r_reg = i_cfg_data[30:0];
                    tak_pkg::REG_INITIAL_BIAS:  bias0_reg = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                estimate_queue.push_back(filter_word(i_in_user, i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (estimate_queue.size() == 0) begin
                    $error("result word with no expectation waiting");
                    fails++;
                end else begin
                    want = estimate_queue.pop_front();
                    if (i_out_data[31:0] !== want.angle) begin
                        $error("angle_estimate: expected %h, actual %h",
                               want.angle, i_out_data[31:0]);
                        fails++;
                    end
                    if (i_out_data[63:32] !== want.bias) begin
                        $error("bias_estimate: expected %h, actual %h",
                               want.bias, i_out_data[63:32]);
                        fails++;
                    end
                    if (i_out_user !== want.fault) begin
                        $error("divide_fault: expected %b, actual %b",
                               want.fault, i_out_user);
                        fails++;
                    end
                end
            end
        end
        o_pending = estimate_queue.size();
    end

    assign o_fail_count = fails;
endmodule

`default_nettype wire

>>> tb/tilt_angle_kalman_filter_test.sv
// ============================================================================
// tilt_angle_kalman_filter_test: regression of the tilt angle Kalman filter
// Drives directed and random words under several register settings with
// random gaps on both sides; the checker predicts and compares every result.
// ============================================================================
`default_nettype none

module tilt_angle_kalman_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    // A quiet stretch of this many cycles with nothing accepted anywhere
    // means the block has hung.
    localparam int STALL_LIMIT = 4000;
    // An index past the end of the register list.
    localparam tak_pkg::t_reg_index REG_UNUSED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] in_data = '0;
    logic        in_user = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_data;
    logic        out_user;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    tilt_angle_kalman_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
        .s_axis_tdata(in_data),     // [31:0] measured_angle, [63:32] gyro_rate
        .s_axis_tuser(in_user),     // [0] operation
        .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
        .m_axis_tdata(out_data),    // [31:0] angle_estimate, [63:32] bias_estimate
        .m_axis_tuser(out_user)     // [0] divide_fault
    );

    tilt_angle_kalman_filter_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_data(in_data), .i_in_user(in_user),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_data(out_data), .i_out_user(out_user),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // The result side stalls on its own schedule.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) < 70) ||
                         ($urandom_range(0, 99) < 5);
        end
    end

    // The watchdog restarts its count on every accepted word.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tilt_angle_kalman_filter regression: fail");
            $finish;
        end
    end

    // Drops valid as soon as the write is taken so the next task starts clean.
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one word after a random gap and holds it until it is taken.
    task automatic send_word(input logic op, input logic [31:0] angle,
                             input logic [31:0] rate);
        int gap;
        gap = gap_length();
        repeat (gap) @(posedge i_clk);
        in_valid <= 1'b1;
        in_user <= op;
        in_data <= {rate, angle};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every predicted result has come back, then for the
    // block's latency so that nothing is left in work.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Random value biased toward the extremes and toward small magnitudes.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    task automatic random_settings();
        write_register(tak_pkg::REG_TIME_STEP, $urandom_range(0, 32'h0040_0000));
        write_register(tak_pkg::REG_ANGLE_NOISE, $urandom_range(0, 32'h0010_0000));
        write_register(tak_pkg::REG_BIAS_NOISE, $urandom_range(0, 32'h0040_0000));
        write_register(tak_pkg::REG_MEASURE_NOISE, $urandom_range(0, 32'h0100_0000));
        write_register(tak_pkg::REG_INITIAL_BIAS,
                       $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
    endtask

    initial begin
        int phase;
        int item;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings first, with both operations and extremes.
        send_word(tak_pkg::OP_SAMPLE, 32'h0001_0000, 32'h0000_8000);
        send_word(tak_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(tak_pkg::OP_SAMPLE, 32'h8000_0000, 32'h8000_0000);
        send_word(tak_pkg::OP_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(tak_pkg::OP_SAMPLE, 32'h0000_0000, 32'h0000_0000);
        drain();

        // Zero noise terms with a cleared covariance make the innovation
        // variance zero, which forces the gains to zero.
        write_register(tak_pkg::REG_ANGLE_NOISE, 32'd0);
        write_register(tak_pkg::REG_MEASURE_NOISE, 32'd0);
        write_register(tak_pkg::REG_BIAS_NOISE, 32'd0);
        write_register(tak_pkg::REG_INITIAL_BIAS, 32'h8000_0000);
        send_word(tak_pkg::OP_RESTART, 32'd0, 32'd0);
        send_word(tak_pkg::OP_SAMPLE, 32'h0010_0000, 32'h7FFF_FFFF);
        send_word(tak_pkg::OP_SAMPLE, 32'h8000_0000, 32'h0000_0001);
        drain();

        // Largest time step and noise, with a positive extreme bias that only
        // takes effect at the next restart; bit 31 of the 31-bit registers
        // is set to show that it is dropped.
        write_register(tak_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
        write_register(tak_pkg::REG_ANGLE_NOISE, 32'hFFFF_FFFF);
        write_register(tak_pkg::REG_BIAS_NOISE, 32'hFFFF_FFFF);
        write_register(tak_pkg::REG_MEASURE_NOISE, 32'hFFFF_FFFF);
        write_register(tak_pkg::REG_INITIAL_BIAS, 32'h7FFF_FFFF);
        write_register(REG_UNUSED, 32'h1234_5678);
        send_word(tak_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(tak_pkg::OP_RESTART, 32'd0, 32'd0);
        for (item = 0; item < 8; item++)
            send_word(tak_pkg::OP_SAMPLE, $urandom(), $urandom());
        drain();

        // Random phases, each under a fresh setting; a restart now and then
        // keeps the filter from staying pinned at saturation.
        for (phase = 0; phase < 9; phase++) begin
            random_settings();
            send_word(tak_pkg::OP_RESTART, $urandom(), $urandom());
            for (item = 0; item < 200; item++) begin
                if ($urandom_range(0, 99) < 4)
                    send_word(tak_pkg::OP_RESTART, $urandom(), $urandom());
                else
                    send_word(tak_pkg::OP_SAMPLE, pick_word(), pick_word());
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tilt_angle_kalman_filter regression: pass");
        end else begin
            $display("tilt_angle_kalman_filter regression: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
